FILE: src/ffra_pkg.sv
// ffra_pkg: shared types and constants of the first-fit region allocator
// used by ffra_ctrl, ffra_dp and first_fit_region_allocator; no dependencies
`default_nettype none

package ffra_pkg;

  localparam int MAX_REGIONS_DEF = 16;
  localparam int ADDR_BITS_DEF   = 16;
  localparam int HEAP_BASE_RST   = 1024;
  localparam int ALIGN           = 8;

  // item kinds, carried in tuser
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // configuration register indexes
  localparam logic REG_HEAP_BASE  = 1'b0;
  localparam logic REG_HEAP_LIMIT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ALLOC,
    ST_FREE,
    ST_INSERT,
    ST_REMOVE,
    ST_DONE_ALLOC,
    ST_DONE_FREE,
    ST_DONE_FAIL
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic start;        // capture item, rewind walk
    logic step;         // advance walk by one entry
    logic insert;       // place region at walk index
    logic remove;       // drop entry at walk index
    logic load;         // load the result register
    logic ok;           // result flag
    logic from_cursor;  // result start is the cursor, else zero
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic full;
    logic at_end;
    logic gap_fits;
    logic tail_fits;
    logic match;
  } status_t;

endpackage

`default_nettype wire

FILE: src/ffra_dp.sv
// ffra_dp: region table, walk cursor, config registers and result register
// depends on ffra_pkg for cmd_t, status_t and reset constants
`default_nettype none

module ffra_dp #(
  parameter int MAX_REGIONS = ffra_pkg::MAX_REGIONS_DEF,
  parameter int ADDR_BITS   = ffra_pkg::ADDR_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic                  cfg_index,
  input  wire logic [ADDR_BITS-1:0]  cfg_data,
  input  wire logic [ADDR_BITS-1:0]  request_size,
  input  wire logic [ADDR_BITS-1:0]  release_start,
  input  wire ffra_pkg::cmd_t        cmd,
  output ffra_pkg::status_t          status,
  output logic      [ADDR_BITS-1:0]  region_start,
  output logic                       ok
);

  localparam int CNT_W = $clog2(MAX_REGIONS + 1);
  localparam int IDX_W = $clog2(MAX_REGIONS);
  localparam int LEN_W = ADDR_BITS + 1;
  localparam int CMP_W = ADDR_BITS + 2;

  logic [ADDR_BITS-1:0] heap_base;
  logic [ADDR_BITS-1:0] heap_limit;
  logic [ADDR_BITS-1:0] starts  [MAX_REGIONS];
  logic [LEN_W-1:0]     lengths [MAX_REGIONS];
  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     idx;
  logic [LEN_W-1:0]     cursor;
  logic [LEN_W-1:0]     size;
  logic [ADDR_BITS-1:0] key;

  logic [IDX_W-1:0]     idx_s;
  logic [ADDR_BITS-1:0] cur_start;
  logic [LEN_W-1:0]     cur_end;
  logic [CMP_W-1:0]     need;
  logic [LEN_W-1:0]     size_round;

  assign idx_s     = idx[IDX_W-1:0];
  assign cur_start = starts[idx_s];
  assign cur_end   = {1'b0, cur_start} + lengths[idx_s];
  assign need      = {1'b0, cursor} + {1'b0, size};

  // round up to the allocation grain
  assign size_round = ({1'b0, request_size} + LEN_W'(ffra_pkg::ALIGN - 1))
                      & ~LEN_W'(ffra_pkg::ALIGN - 1);

  always_comb begin
    status.full      = (count == CNT_W'(MAX_REGIONS));
    status.at_end    = (idx == count);
    status.gap_fits  = ({2'b00, cur_start} >= need);
    status.tail_fits = ({2'b00, heap_limit} >= need);
    status.match     = (cur_start == key);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_base  <= ADDR_BITS'(ffra_pkg::HEAP_BASE_RST);
      heap_limit <= '1;
    end else if (cfg_we) begin
      if (cfg_index == ffra_pkg::REG_HEAP_BASE) begin
        heap_base <= cfg_data;
      end else begin
        heap_limit <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.insert) begin
      count <= count + CNT_W'(1);
    end else if (cmd.remove) begin
      count <= count - CNT_W'(1);
    end
  end

  // walk state
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      idx    <= '0;
      cursor <= {1'b0, heap_base};
      size   <= size_round;
      key    <= release_start;
    end else if (cmd.step) begin
      idx <= idx + CNT_W'(1);
      if (cur_end > cursor) begin
        cursor <= cur_end;
      end
    end
  end

  // table update: every live entry past the walk index moves one place at once
  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      for (int j = 1; j < MAX_REGIONS; j++) begin
        if (CNT_W'(j) > idx && CNT_W'(j) <= count) begin
          starts[j]  <= starts[j-1];
          lengths[j] <= lengths[j-1];
        end
      end
      starts[idx_s]  <= cursor[ADDR_BITS-1:0];
      lengths[idx_s] <= size;
    end else if (cmd.remove) begin
      for (int j = 0; j < MAX_REGIONS - 1; j++) begin
        if (CNT_W'(j) >= idx && CNT_W'(j + 1) < count) begin
          starts[j]  <= starts[j+1];
          lengths[j] <= lengths[j+1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      region_start <= cmd.from_cursor ? cursor[ADDR_BITS-1:0] : '0;
      ok           <= cmd.ok;
    end
  end

endmodule

`default_nettype wire

FILE: src/ffra_ctrl.sv
// ffra_ctrl: sequencer for walk, insert, remove and result handoff
// depends on ffra_pkg for state_t, cmd_t and status_t
`default_nettype none

module ffra_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  input  wire logic              op,
  output logic                   s_tready,
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  input  wire ffra_pkg::status_t status,
  output ffra_pkg::cmd_t         cmd
);

  ffra_pkg::state_t state;
  ffra_pkg::state_t state_next;
  logic             out_free;

  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ffra_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      ffra_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.start  = 1'b1;
          state_next = (op == ffra_pkg::OP_FREE) ? ffra_pkg::ST_FREE : ffra_pkg::ST_ALLOC;
        end
      end
      ffra_pkg::ST_ALLOC: begin
        if (status.full) begin
          state_next = ffra_pkg::ST_DONE_FAIL;
        end else if (status.at_end) begin
          state_next = status.tail_fits ? ffra_pkg::ST_INSERT : ffra_pkg::ST_DONE_FAIL;
        end else if (status.gap_fits) begin
          state_next = ffra_pkg::ST_INSERT;
        end else begin
          cmd.step = 1'b1;
        end
      end
      ffra_pkg::ST_FREE: begin
        if (status.at_end) begin
          state_next = ffra_pkg::ST_DONE_FAIL;
        end else if (status.match) begin
          state_next = ffra_pkg::ST_REMOVE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      ffra_pkg::ST_INSERT: begin
        cmd.insert = 1'b1;
        state_next = ffra_pkg::ST_DONE_ALLOC;
      end
      ffra_pkg::ST_REMOVE: begin
        cmd.remove = 1'b1;
        state_next = ffra_pkg::ST_DONE_FREE;
      end
      ffra_pkg::ST_DONE_ALLOC: begin
        if (out_free) begin
          cmd.load        = 1'b1;
          cmd.ok          = 1'b1;
          cmd.from_cursor = 1'b1;
          state_next      = ffra_pkg::ST_IDLE;
        end
      end
      ffra_pkg::ST_DONE_FREE: begin
        if (out_free) begin
          cmd.load   = 1'b1;
          cmd.ok     = 1'b1;
          state_next = ffra_pkg::ST_IDLE;
        end
      end
      ffra_pkg::ST_DONE_FAIL: begin
        if (out_free) begin
          cmd.load   = 1'b1;
          state_next = ffra_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = ffra_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: src/first_fit_region_allocator.sv
// First-fit region allocator over a table of up to MAX_REGIONS regions kept
// sorted by start. An allocate beat rounds its size up to a multiple of 8 and walks the table
// one entry per cycle from heap_base looking for the first gap that fits, then
// inserts the region there (all later entries move up together) or
// appends it below heap_limit. A free beat walks for the matching start and
// closes the hole. From its beat to its result an item walks the table one entry
// at a time, decides, inserts or removes when that is needed and then loads the
// result once the result register is free; the next beat is taken the cycle
// after the load. One item is in work at a time, and the result register lets
// the next beat be taken while a result waits. region_start is 0 for a free or
// on failure; ok tells success. Write configuration only while no item is in
// work.
`default_nettype none

module first_fit_region_allocator #(
  parameter int MAX_REGIONS = ffra_pkg::MAX_REGIONS_DEF,
  parameter int ADDR_BITS   = ffra_pkg::ADDR_BITS_DEF,
  localparam int IN_W       = ((2 * ADDR_BITS + 7) / 8) * 8,
  localparam int OUT_W      = ((ADDR_BITS + 7) / 8) * 8
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_we,
  input  wire logic                     cfg_index,
  input  wire logic [ADDR_BITS-1:0]     cfg_data,
  input  wire logic                     s_tvalid,
  output logic                          s_tready,
  // request_size, release_start, zero fill
  input  wire logic [IN_W-1:0]          s_tdata,
  // op
  input  wire logic                     s_tuser,
  output logic                          m_tvalid,
  input  wire logic                     m_tready,
  // region_start, zero fill
  output logic      [OUT_W-1:0]         m_tdata,
  // ok
  output logic                          m_tuser
);

  ffra_pkg::cmd_t       cmd;
  ffra_pkg::status_t    status;
  logic [ADDR_BITS-1:0] region_start;

  ffra_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .op       (s_tuser),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  ffra_dp #(
    .MAX_REGIONS (MAX_REGIONS),
    .ADDR_BITS   (ADDR_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .request_size  (s_tdata[ADDR_BITS-1:0]),
    .release_start (s_tdata[2*ADDR_BITS-1:ADDR_BITS]),
    .cmd           (cmd),
    .status        (status),
    .region_start  (region_start),
    .ok            (m_tuser)
  );

  assign m_tdata = OUT_W'(region_start);

endmodule

`default_nettype wire

FILE: bench/testbench.sv
// testbench for first_fit_region_allocator: stream stimulus with a self-checking
// region table that predicts every grant; depends on ffra_pkg and the allocator rtl
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS       = ffra_pkg::MAX_REGIONS_DEF;
  localparam int AW          = ffra_pkg::ADDR_BITS_DEF;
  localparam int SETTLE      = SLOTS + 8;
  localparam int LONG_HOLD   = 300;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic [AW-1:0] region_start;
    logic          ok;
  } grant_t;

  // mirror of the allocator table plus the queue of grants still owed
  class region_book;
    logic [AW-1:0] base;
    logic [AW-1:0] limit;
    logic [AW-1:0] starts[SLOTS];
    logic [AW:0]   lens[SLOTS];
    int unsigned   count;
    grant_t        grants_due[$];
    int            errors;

    function new();
      base   = ffra_pkg::HEAP_BASE_RST;
      limit  = '1;
      count  = 0;
      errors = 0;
      foreach (starts[i]) begin
        starts[i] = '0;
        lens[i]   = '0;
      end
    endfunction

    function void set_heap(logic [AW-1:0] new_base, logic [AW-1:0] new_limit);
      base  = new_base;
      limit = new_limit;
    endfunction

    function void place(int unsigned slot, int unsigned at, int unsigned len);
      for (int unsigned i = count; i > slot; i--) begin
        starts[i] = starts[i-1];
        lens[i]   = lens[i-1];
      end
      starts[slot] = at[AW-1:0];
      lens[slot]   = len[AW:0];
      count++;
    endfunction

    function grant_t predict_alloc(logic [AW-1:0] req);
      grant_t      g;
      int unsigned size;
      int unsigned cursor;
      int unsigned s;
      int unsigned e;
      g.region_start = '0;
      g.ok           = 1'b0;
      size   = ({16'd0, req} + 32'd7) & ~32'd7;
      cursor = base;
      if (count >= SLOTS) return g;
      for (int unsigned i = 0; i < count; i++) begin
        s = starts[i];
        e = s + lens[i];
        // entries below the cursor never offer a gap
        if (s >= cursor && s - cursor >= size) begin
          place(i, cursor, size);
          g.region_start = cursor[AW-1:0];
          g.ok           = 1'b1;
          return g;
        end
        if (e > cursor) cursor = e;
      end
      if (cursor <= limit && limit - cursor >= size) begin
        place(count, cursor, size);
        g.region_start = cursor[AW-1:0];
        g.ok           = 1'b1;
      end
      return g;
    endfunction

    function grant_t predict_free(logic [AW-1:0] rel);
      grant_t g;
      g.region_start = '0;
      g.ok           = 1'b0;
      for (int unsigned i = 0; i < count; i++) begin
        if (starts[i] == rel) begin
          for (int unsigned j = i; j + 1 < count; j++) begin
            starts[j] = starts[j+1];
            lens[j]   = lens[j+1];
          end
          starts[count-1] = '0;
          lens[count-1]   = '0;
          count--;
          g.ok = 1'b1;
          return g;
        end
      end
      return g;
    endfunction

    function void note_request(logic op, logic [AW-1:0] req, logic [AW-1:0] rel);
      if (op == ffra_pkg::OP_FREE) grants_due.push_back(predict_free(rel));
      else grants_due.push_back(predict_alloc(req));
    endfunction

    function void check_grant(logic [AW-1:0] got_start, logic got_ok);
      grant_t want;
      if (grants_due.size() == 0) begin
        $display("%0t: unexpected result beat: region_start %0d ok %0b",
                 $time, got_start, got_ok);
        errors++;
        return;
      end
      want = grants_due.pop_front();
      if (got_start !== want.region_start) begin
        $display("%0t: region_start mismatch: expected %0d, actual %0d",
                 $time, want.region_start, got_start);
        errors++;
      end
      if (got_ok !== want.ok) begin
        $display("%0t: ok mismatch: expected %0b, actual %0b", $time, want.ok, got_ok);
        errors++;
      end
    endfunction
  endclass

  logic          clk;
  logic          rst       = 1'b1;
  logic          cfg_we    = 1'b0;
  logic          cfg_index = ffra_pkg::REG_HEAP_BASE;
  logic [AW-1:0] cfg_data  = '0;
  logic          s_tvalid  = 1'b0;
  logic          s_tready;
  logic [31:0]   s_tdata   = '0;  // request_size, release_start
  logic          s_tuser   = ffra_pkg::OP_ALLOC;  // op
  logic          m_tvalid;
  logic          m_tready  = 1'b0;
  logic [15:0]   m_tdata;         // region_start
  logic          m_tuser;         // ok

  region_book book = new();
  int         idle_pct  = 20;
  int         hold_asks = 0;
  int         cycles    = 0;

  first_fit_region_allocator u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    while (cycles < CYCLE_LIMIT) @(posedge clk) cycles++;
    $display("Simulation FAILED");
    $finish;
  end

  // result side: checks every beat and stalls in bursts or for a long hold
  initial begin : result_sink
    int hold_left;
    int stall_left;
    int hold_seen;
    hold_left  = 0;
    stall_left = 0;
    hold_seen  = 0;
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) book.check_grant(m_tdata[AW-1:0], m_tuser);
      if (hold_asks != hold_seen) begin
        hold_seen = hold_asks;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
        stall_left = $urandom_range(1, 13) - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic send_item(logic op, logic [AW-1:0] req, logic [AW-1:0] rel);
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {rel, req};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    book.note_request(op, req, rel);
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  // the unused field of each beat carries random noise
  task automatic ask_region(logic [AW-1:0] size);
    send_item(ffra_pkg::OP_ALLOC, size, AW'($urandom));
  endtask

  task automatic drop_region(logic [AW-1:0] start);
    send_item(ffra_pkg::OP_FREE, AW'($urandom), start);
  endtask

  task automatic wait_drain();
    s_tvalid <= 1'b0;
    while (book.grants_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_heap(logic [AW-1:0] new_base, logic [AW-1:0] new_limit);
    cfg_we    <= 1'b1;
    cfg_index <= ffra_pkg::REG_HEAP_BASE;
    cfg_data  <= new_base;
    @(posedge clk);
    cfg_index <= ffra_pkg::REG_HEAP_LIMIT;
    cfg_data  <= new_limit;
    @(posedge clk);
    cfg_we <= 1'b0;
    book.set_heap(new_base, new_limit);
  endtask

  function automatic logic [AW-1:0] pick_size();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) return AW'($urandom_range(0, 24));
    if (roll < 80) return AW'($urandom_range(25, 512));
    if (roll < 95) return AW'($urandom_range(513, 8192));
    return AW'($urandom);
  endfunction

  // mostly frees of live regions and allocations, some frees that miss
  task automatic random_item();
    int unsigned alloc_pct;
    if (book.count == 0) alloc_pct = 80;
    else if (book.count >= SLOTS) alloc_pct = 15;
    else alloc_pct = 55;
    if ($urandom_range(0, 99) < alloc_pct) ask_region(pick_size());
    else if (book.count > 0 && $urandom_range(0, 9) < 7)
      drop_region(book.starts[$urandom_range(0, book.count - 1)]);
    else drop_region(AW'($urandom));
  endtask

  task automatic run_phase(logic [AW-1:0] new_base, logic [AW-1:0] new_limit,
                           int n, int pct, bit long_hold);
    wait_drain();
    set_heap(new_base, new_limit);
    idle_pct = pct;
    if (long_hold) hold_asks++;
    repeat (n) random_item();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // zero sizes give duplicate starts, the largest sizes never fit
    ask_region(16'd0);
    ask_region(16'd0);
    ask_region(16'd1);
    ask_region(16'd7);
    ask_region(16'd8);
    ask_region(16'd9);
    ask_region(16'hFFFF);
    ask_region(16'hFFF8);
    drop_region(16'd1024);
    drop_region(16'd3);
    drop_region(16'hFFFF);
    drop_region(16'd0);
    while (book.count < SLOTS) ask_region(16'd100);
    ask_region(16'd8);
    drop_region(book.starts[5]);
    drop_region(book.starts[9]);
    ask_region(16'd8);
    ask_region(16'd50);
    repeat (100) random_item();

    run_phase(16'd0,     16'hFFFF, 220, 25, 1'b1);
    run_phase(16'd4096,  16'd8191, 200, 0,  1'b0);
    run_phase(16'hFFFF,  16'hFFFF, 150, 30, 1'b0);
    run_phase(16'd0,     16'd0,    150, 15, 1'b1);
    run_phase(16'd2000,  16'd1500, 150, 25, 1'b0);
    run_phase(16'd1024,  16'hFFFF, 250, 20, 1'b0);
    run_phase(16'd512,   16'd3000, 250, 0,  1'b0);

    wait_drain();
    if (book.errors == 0 && book.grants_due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
